>>> rtl/ddm_pkg.sv
// ddm_pkg: shared widths, constants, codes and control structs of the drive mixer
// no dependencies; used by the interfaces, the controller, the datapath and the top
`default_nettype none

package ddm_pkg;

    // gear range and register reset
    localparam int TOP_GEAR = 10;
    localparam int GEAR_W   = 4;
    localparam int CFG_W    = 15;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 15'd7000;

    // command and result widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int MIX_W = IN_W + 1;
    localparam logic [MIX_W-1:0] UNIT_Q12 = 17'd4096;

    // multiply and divide widths; the quotient never exceeds max_speed
    localparam int PROD_W = MIX_W + CFG_W;
    localparam int NUM_W  = PROD_W + GEAR_W;
    localparam int QUOT_W = CFG_W;
    localparam int STEP_W = $clog2(QUOT_W);

    // operation codes
    typedef enum logic {
        OP_BUTTON   = 1'b0,
        OP_VELOCITY = 1'b1
    } ddm_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mix;
        logic mult;
        logic scale;
        logic div;
        logic commit;
    } ddm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic velocity;
    } ddm_sts_t;

endpackage

`default_nettype wire

>>> rtl/ddm_if.sv
// ddm_if: valid/ready channel interfaces for commands, results and configuration
// depends on ddm_pkg for field widths
`default_nettype none

interface ddm_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic                           button_faster;
    logic                           button_slower;
    logic                           button_ahead;
    logic                           button_back;
    logic signed [ddm_pkg::IN_W-1:0] linear;
    logic signed [ddm_pkg::IN_W-1:0] angular;

    modport source (
        output valid, operation, button_faster, button_slower, button_ahead,
               button_back, linear, angular,
        input  ready
    );
    modport sink (
        input  valid, operation, button_faster, button_slower, button_ahead,
               button_back, linear, angular,
        output ready
    );
endinterface

interface ddm_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [ddm_pkg::OUT_W-1:0]  left_speed;
    logic signed [ddm_pkg::OUT_W-1:0]  right_speed;
    logic        [ddm_pkg::GEAR_W-1:0] gear_level;
    logic                             reversing;

    modport source (
        output valid, left_speed, right_speed, gear_level, reversing,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, gear_level, reversing,
        output ready
    );
endinterface

interface ddm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ddm_pkg::CFG_W-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/ddm_ctrl.sv
// ddm_ctrl: sequencing state machine, divide step counter and result valid flag
// depends on ddm_pkg for the command and status structs
`default_nettype none

module ddm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    input  wire ddm_pkg::ddm_sts_t sts,
    output      ddm_pkg::ddm_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MIX    = 6'b000010,
        S_MULT   = 6'b000100,
        S_SCALE  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    localparam logic [ddm_pkg::STEP_W-1:0] LAST_STEP =
        ddm_pkg::STEP_W'(ddm_pkg::QUOT_W - 1);

    state_t                        state_reg, state_next;
    logic [ddm_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          commit;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        commit     = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = sts.velocity ? S_MULT : S_FINISH;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                cnt_next   = '0;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.commit = commit;
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a committed result is offered at the next edge
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("result not offered after commit");

    // a button event skips the arithmetic
    a_button_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) && !sts.velocity |=> (state_reg == S_FINISH))
        else $error("button event entered the arithmetic");

    // the divider runs exactly its step count
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) && (cnt_reg == LAST_STEP) |=> (state_reg == S_FINISH))
        else $error("divide did not end after its last step");
`endif

endmodule

`default_nettype wire

>>> rtl/ddm_dp.sv
// ddm_dp: gear and direction state, side mixing, scaling multiplies, two divide lanes
// depends on ddm_pkg; sequenced by ddm_ctrl
`default_nettype none

module ddm_dp #(
    parameter int TopGear = ddm_pkg::TOP_GEAR
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ddm_pkg::ddm_cmd_t                  cmd,
    output      ddm_pkg::ddm_sts_t                  sts,
    input  wire logic                               cfg_we,
    input  wire logic        [ddm_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                               operation,
    input  wire logic                               button_faster,
    input  wire logic                               button_slower,
    input  wire logic                               button_ahead,
    input  wire logic                               button_back,
    input  wire logic signed [ddm_pkg::IN_W-1:0]    linear,
    input  wire logic signed [ddm_pkg::IN_W-1:0]    angular,
    output      logic signed [ddm_pkg::OUT_W-1:0]   left_speed,
    output      logic signed [ddm_pkg::OUT_W-1:0]   right_speed,
    output      logic        [ddm_pkg::GEAR_W-1:0]  gear_level,
    output      logic                               reversing
);

    localparam int MIX_W  = ddm_pkg::MIX_W;
    localparam int CFG_W  = ddm_pkg::CFG_W;
    localparam int GEAR_W = ddm_pkg::GEAR_W;
    localparam int OUT_W  = ddm_pkg::OUT_W;
    localparam int PROD_W = ddm_pkg::PROD_W;
    localparam int NUM_W  = ddm_pkg::NUM_W;
    localparam int QUOT_W = ddm_pkg::QUOT_W;
    localparam int DEN_W  = MIX_W + $clog2(TopGear + 1);
    localparam logic [GEAR_W-1:0] GEAR_TOP = GEAR_W'(TopGear);

    // captured command
    logic                        op_reg;
    logic                        faster_reg, slower_reg, ahead_reg, back_reg;
    logic signed [MIX_W-2:0]     lin_reg, ang_reg;

    // architectural state
    logic [CFG_W-1:0]            max_speed_reg;
    logic [GEAR_W-1:0]           gear_reg;
    logic                        rev_reg;
    logic                        last_faster_reg, last_slower_reg;
    logic                        last_ahead_reg, last_back_reg;
    logic signed [OUT_W-1:0]     held_left_reg, held_right_reg;

    // arithmetic pipeline, lane 0 is the left side, lane 1 the right side
    logic [MIX_W-1:0]            mag_reg [2];
    logic                        neg_reg [2];
    logic [DEN_W-1:0]            den_reg;
    logic [PROD_W-1:0]           prod_reg [2];
    logic [DEN_W-1:0]            rem_reg [2];
    logic [QUOT_W-1:0]           quo_reg [2];

    logic signed [MIX_W-1:0]     side [2];
    logic [MIX_W-1:0]            mag [2];
    logic [MIX_W-1:0]            peak, base;
    logic [NUM_W-1:0]            num [2];
    logic [DEN_W:0]              trial [2];
    logic [DEN_W:0]              diff [2];
    logic                        fits [2];
    logic [DEN_W-1:0]            rem_step [2];
    logic signed [OUT_W-1:0]     qv [2];

    logic [GEAR_W-1:0]           gear_up, gear_new;
    logic                        rev_new;
    logic signed [OUT_W-1:0]     left_new, right_new;

    assign sts.velocity = (op_reg == ddm_pkg::OP_VELOCITY);

    // side mixing and magnitudes
    always_comb
    begin
        side[0] = {lin_reg[MIX_W-2], lin_reg} - {ang_reg[MIX_W-2], ang_reg};
        side[1] = {lin_reg[MIX_W-2], lin_reg} + {ang_reg[MIX_W-2], ang_reg};
        for (int i = 0; i < 2; i++)
        begin
            mag[i] = side[i][MIX_W-1] ? MIX_W'(-side[i]) : MIX_W'(side[i]);
        end
        peak = (mag[0] > mag[1]) ? mag[0] : mag[1];
        base = (peak > ddm_pkg::UNIT_Q12) ? peak : ddm_pkg::UNIT_Q12;
    end

    // gear scaling and one restoring divide step per lane
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            num[i]      = NUM_W'(prod_reg[i]) * NUM_W'(gear_reg);
            trial[i]    = {rem_reg[i], quo_reg[i][QUOT_W-1]};
            diff[i]     = trial[i] - {1'b0, den_reg};
            fits[i]     = (trial[i] >= {1'b0, den_reg});
            rem_step[i] = fits[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
            qv[i]       = OUT_W'(quo_reg[i]);
        end
    end

    // button edges update gear and direction
    always_comb
    begin
        gear_up  = gear_reg;
        gear_new = gear_reg;
        rev_new  = rev_reg;
        if (faster_reg && !last_faster_reg)
        begin
            gear_up = (gear_reg >= GEAR_TOP) ? GEAR_TOP : gear_reg + 1'b1;
        end
        gear_new = gear_up;
        if (slower_reg && !last_slower_reg)
        begin
            if (gear_up == '0)
            begin
                gear_new = '0;
            end
            else if (gear_up > GEAR_TOP)
            begin
                gear_new = GEAR_TOP;
            end
            else
            begin
                gear_new = gear_up - 1'b1;
            end
        end
        if (ahead_reg && !last_ahead_reg)
        begin
            rev_new = 1'b0;
        end
        if (back_reg && !last_back_reg)
        begin
            rev_new = 1'b1;
        end
    end

    // signed wheel speeds, right side mirrored
    always_comb
    begin
        left_new  = (neg_reg[0] ^ rev_reg) ? -qv[0] : qv[0];
        right_new = (neg_reg[1] ^ rev_reg) ? qv[1] : -qv[1];
    end

    // command capture and arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            faster_reg <= button_faster;
            slower_reg <= button_slower;
            ahead_reg  <= button_ahead;
            back_reg   <= button_back;
            lin_reg    <= linear;
            ang_reg    <= angular;
        end
        if (cmd.mix)
        begin
            den_reg <= DEN_W'(base) * DEN_W'(TopGear);
        end
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.mix)
            begin
                mag_reg[i] <= mag[i];
                neg_reg[i] <= side[i][MIX_W-1];
            end
            if (cmd.mult)
            begin
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(max_speed_reg);
            end
            if (cmd.scale)
            begin
                rem_reg[i] <= DEN_W'(num[i] >> QUOT_W);
                quo_reg[i] <= num[i][QUOT_W-1:0];
            end
            else if (cmd.div)
            begin
                rem_reg[i] <= rem_step[i];
                quo_reg[i] <= {quo_reg[i][QUOT_W-2:0], fits[i]};
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (sts.velocity)
            begin
                left_speed  <= left_new;
                right_speed <= right_new;
                gear_level  <= gear_reg;
                reversing   <= rev_reg;
            end
            else
            begin
                left_speed  <= held_left_reg;
                right_speed <= held_right_reg;
                gear_level  <= gear_new;
                reversing   <= rev_new;
            end
        end
    end

    // configuration and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg   <= ddm_pkg::MAX_SPEED_RST;
            gear_reg        <= '0;
            rev_reg         <= 1'b0;
            last_faster_reg <= 1'b0;
            last_slower_reg <= 1'b0;
            last_ahead_reg  <= 1'b0;
            last_back_reg   <= 1'b0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_speed_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                if (sts.velocity)
                begin
                    held_left_reg  <= left_new;
                    held_right_reg <= right_new;
                end
                else
                begin
                    gear_reg        <= gear_new;
                    rev_reg         <= rev_new;
                    last_faster_reg <= faster_reg;
                    last_slower_reg <= slower_reg;
                    last_ahead_reg  <= ahead_reg;
                    last_back_reg   <= back_reg;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // gear never leaves its range
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        gear_reg <= GEAR_TOP)
        else $error("gear above top gear");

    // partial remainders stay below the divisor while dividing
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |-> (rem_reg[0] < den_reg) && (rem_reg[1] < den_reg))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/differential_drive_mixer_with_gears.sv
// differential_drive_mixer_with_gears: top level joining controller and datapath
// depends on ddm_pkg, ddm_if, ddm_ctrl and ddm_dp
//
//  channel  | dir | transfer carries
//  ---------+-----+------------------------------------------------------------
//  cmd      | in  | operation, four button levels, linear and angular (Q3.12)
//  result   | out | left_speed, right_speed, gear_level, reversing
//  cfg      | in  | max_speed write data, always ready
//
// a velocity command passes mix, multiply, scale and the restoring divider,
// one quotient bit per cycle in each lane, then finish before the next ready.
// a button event skips to finish. one command is in work at a time; the next is
// taken while the previous result still waits in the output register.
// reset sets max_speed to 7000 and clears gear, direction, button history and
// held speeds. a stalled result holds the finished command in its last state.
`default_nettype none

module differential_drive_mixer_with_gears #(
    parameter int TopGear = ddm_pkg::TOP_GEAR
) (
    input wire logic  clk,
    input wire logic  rst_n,
    ddm_cmd_if.sink   cmd,
    ddm_res_if.source result,
    ddm_cfg_if.sink   cfg
);

    ddm_pkg::ddm_cmd_t ctl_cmd;
    ddm_pkg::ddm_sts_t dp_sts;
    logic              cmd_ready;
    logic              res_valid;

    // configuration is taken every cycle
    assign cfg.ready    = 1'b1;
    assign cmd.ready    = cmd_ready;
    assign result.valid = res_valid;

    // sequencer
    ddm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd_ready),
        .out_valid (res_valid),
        .out_ready (result.ready),
        .sts       (dp_sts),
        .cmd       (ctl_cmd)
    );

    // arithmetic and state
    ddm_dp #(
        .TopGear (TopGear)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl_cmd),
        .sts           (dp_sts),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.data),
        .operation     (cmd.operation),
        .button_faster (cmd.button_faster),
        .button_slower (cmd.button_slower),
        .button_ahead  (cmd.button_ahead),
        .button_back   (cmd.button_back),
        .linear        (cmd.linear),
        .angular       (cmd.angular),
        .left_speed    (result.left_speed),
        .right_speed   (result.right_speed),
        .gear_level    (result.gear_level),
        .reversing     (result.reversing)
    );

endmodule

`default_nettype wire
